FILE: hdl/dltq_pkg.sv
// Shared types and constants of the delta-list timer queue.
// Used by the front, back and top-level modules; depends on nothing.
package dltq_pkg;

   localparam int SLOT_SPACE = 16;
   localparam int MAX_BURST  = 16;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_DEL = 2'd1;

   localparam logic [2:0] ST_DONE           = 3'd0;
   localparam logic [2:0] ST_EXPIRED        = 3'd1;
   localparam logic [2:0] ST_ZERO_DELAY     = 3'd2;
   localparam logic [2:0] ST_ALREADY_ACTIVE = 3'd3;
   localparam logic [2:0] ST_NOT_ACTIVE     = 3'd4;

   typedef enum logic [1:0] {
      K_ADD,
      K_DEL,
      K_TICK,
      K_ZERO
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   slot;
      logic [7:0]   owner;
      logic [31:0]  delay;
   } cmd_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot;
      logic [7:0] owner;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  slot;
      logic [7:0]  owner;
      logic [31:0] delta;
   } qent_type;

endpackage

FILE: hdl/delta_list_timer_queue.sv
// Channel   Ports                                                   Handshake
// request   req_opcode req_timer_slot req_owner_id req_delay_ticks  push / full
// result    rsp_status rsp_slot_out rsp_owner_out rsp_last          pop / empty
//
// Add and delete walk the rotating delta list in the back end, rotating past
// each queued timer in turn; an add that lands inside the list also inserts
// itself in place during the walk. A tick decrements the head delta, then pops
// each expired timer in turn; a tick on an empty list does nothing. Reset is
// synchronous and empties the list. Either side may stall; two-entry queues
// sit on the request and result sides.
// Depends on dltq_pkg, dltq_front, dltq_back and dltq_fifo.
module delta_list_timer_queue
   import dltq_pkg::*;
#(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_timer_slot,
   input  logic [7:0]  req_owner_id,
   input  logic [31:0] req_delay_ticks,
   input  logic        push,
   output logic        full,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot_out,
   output logic [7:0]  rsp_owner_out,
   output logic        rsp_last,
   output logic        empty,
   input  logic        pop
);
   logic    cmd_valid, cmd_pop, out_full, out_push;
   cmd_type cmd_data;
   rsp_type out_data, rsp_data;

   dltq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_timer_slot  (req_timer_slot),
      .req_owner_id    (req_owner_id),
      .req_delay_ticks (req_delay_ticks),
      .push            (push),
      .full            (full),
      .cmd_valid       (cmd_valid),
      .cmd_data        (cmd_data),
      .cmd_pop         (cmd_pop)
   );

   dltq_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   dltq_fifo #(.WIDTH($bits(rsp_type))) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_data),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .full    (out_full),
      .empty   (empty)
   );

   assign rsp_status    = rsp_data.status;
   assign rsp_slot_out  = rsp_data.slot;
   assign rsp_owner_out = rsp_data.owner;
   assign rsp_last      = rsp_data.last;
endmodule

FILE: hdl/dltq_fifo.sv
// Two-entry queue used on the request side and the result side.
// Depends on nothing.
module dltq_fifo #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      count_in  = count_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end
endmodule

FILE: hdl/dltq_front.sv
// Request side: decodes each request into a command and queues it.
// Depends on dltq_pkg and dltq_fifo.
module dltq_front
   import dltq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_timer_slot,
   input  logic [7:0]  req_owner_id,
   input  logic [31:0] req_delay_ticks,
   input  logic        push,
   output logic        full,
   output logic        cmd_valid,
   output cmd_type     cmd_data,
   input  logic        cmd_pop
);
   cmd_type cmd_in;
   logic    cmd_empty;

   always_comb begin
      cmd_in.slot  = req_timer_slot;
      cmd_in.owner = req_owner_id;
      cmd_in.delay = req_delay_ticks;
      case (req_opcode)
         OP_ADD: begin
            cmd_in.kind = (req_delay_ticks == 32'd0) ? K_ZERO : K_ADD;
         end
         OP_DEL: begin
            cmd_in.kind = K_DEL;
         end
         default: begin
            cmd_in.kind = K_TICK;
         end
      endcase
   end

   dltq_fifo #(.WIDTH($bits(cmd_type))) u_req_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (cmd_in),
      .rd_en   (cmd_pop),
      .rd_data (cmd_data),
      .full    (full),
      .empty   (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;
endmodule

FILE: hdl/dltq_back.sv
// Timer engine: keeps the delta list and carries out add, delete and tick.
// Depends on dltq_pkg.
module dltq_back
   import dltq_pkg::*;
#(
   parameter int NUM_TIMERS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   input  logic    out_full,
   output logic    out_push,
   output rsp_type out_data
);
   localparam int SLOTS = (NUM_TIMERS < SLOT_SPACE) ? NUM_TIMERS : SLOT_SPACE;
   localparam int SIW   = $clog2(SLOTS);
   localparam int IW    = $clog2(NUM_TIMERS);
   localparam int LW    = $clog2(NUM_TIMERS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADD,
      S_DEL,
      S_TICK
   } state_type;

   state_type      state_ff, state_in;
   qent_type       q_ff [NUM_TIMERS];
   qent_type       q_in [NUM_TIMERS];
   logic [LW-1:0]  len_ff, len_in;
   logic [LW-1:0]  cnt_ff, cnt_in;
   logic [LW-1:0]  walk_ff, walk_in;
   logic [4:0]     n_ff, n_in;
   logic [31:0]    rem_ff, rem_in;
   logic           placed_ff, placed_in;
   cmd_type        cmd_ff, cmd_in;
   logic [SLOTS-1:0] active_ff, active_in;
   logic [7:0]     owner_ff [SLOTS];
   logic [7:0]     owner_in [SLOTS];

   logic           rot, popq, app, hd_wr;
   logic [31:0]    hd_val;
   qent_type       head, second;
   logic           slot_ok, cslot_ok;
   logic [SIW-1:0] idx, cidx, hidx;
   logic [7:0]     lk_owner;

   assign head     = q_ff[0];
   assign second   = q_ff[1];
   assign slot_ok  = (int'(cmd_data.slot) < SLOTS);
   assign idx      = cmd_data.slot[SIW-1:0];
   assign cslot_ok = (int'(cmd_ff.slot) < SLOTS);
   assign cidx     = cmd_ff.slot[SIW-1:0];
   assign hidx     = head.slot[SIW-1:0];
   assign lk_owner = slot_ok ? owner_ff[idx] : 8'd0;

   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      walk_in   = walk_ff;
      n_in      = n_ff;
      rem_in    = rem_ff;
      placed_in = placed_ff;
      cmd_in    = cmd_ff;
      active_in = active_ff;
      owner_in  = owner_ff;
      rot       = 1'b0;
      popq      = 1'b0;
      app       = 1'b0;
      hd_wr     = 1'b0;
      hd_val    = head.delta;
      cmd_pop   = 1'b0;
      out_push  = 1'b0;
      out_data  = '0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !out_full) begin
               cmd_pop        = 1'b1;
               out_data.slot  = cmd_data.slot;
               out_data.owner = lk_owner;
               out_data.last  = 1'b1;
               case (cmd_data.kind)
                  K_ZERO: begin
                     out_push        = 1'b1;
                     out_data.status = ST_ZERO_DELAY;
                  end
                  K_ADD: begin
                     if (!slot_ok || active_ff[idx]) begin
                        out_push        = 1'b1;
                        out_data.status = slot_ok ? ST_ALREADY_ACTIVE : ST_NOT_ACTIVE;
                     end else begin
                        cmd_in    = cmd_data;
                        rem_in    = cmd_data.delay;
                        placed_in = 1'b0;
                        cnt_in    = '0;
                        walk_in   = len_ff;
                        state_in  = S_ADD;
                     end
                  end
                  K_DEL: begin
                     if (!slot_ok || !active_ff[idx]) begin
                        out_push        = 1'b1;
                        out_data.status = ST_NOT_ACTIVE;
                     end else begin
                        cmd_in    = cmd_data;
                        placed_in = 1'b0;
                        cnt_in    = '0;
                        walk_in   = len_ff;
                        state_in  = S_DEL;
                     end
                  end
                  default: begin
                     if (len_ff != '0) begin
                        if (head.delta != 32'd0) begin
                           hd_wr  = 1'b1;
                           hd_val = head.delta - 32'd1;
                        end
                        n_in     = '0;
                        state_in = S_TICK;
                     end
                  end
               endcase
            end
         end
         S_ADD: begin
            if (cnt_ff == walk_ff) begin
               if (!out_full) begin
                  app              = !placed_ff;
                  len_in           = placed_ff ? len_ff : len_ff + LW'(1);
                  active_in[cidx]  = 1'b1;
                  owner_in[cidx]   = cmd_ff.owner;
                  out_push         = 1'b1;
                  out_data.status  = ST_DONE;
                  out_data.slot    = cmd_ff.slot;
                  out_data.owner   = cmd_ff.owner;
                  out_data.last    = 1'b1;
                  state_in         = S_IDLE;
               end
            end else if (!placed_ff && rem_ff < head.delta) begin
               app       = 1'b1;
               len_in    = len_ff + LW'(1);
               hd_wr     = 1'b1;
               hd_val    = head.delta - rem_ff;
               placed_in = 1'b1;
            end else begin
               if (!placed_ff) begin
                  rem_in = rem_ff - head.delta;
               end
               rot    = 1'b1;
               cnt_in = cnt_ff + LW'(1);
            end
         end
         S_DEL: begin
            if (cnt_ff == walk_ff) begin
               if (!out_full) begin
                  active_in[cidx] = 1'b0;
                  out_push        = 1'b1;
                  out_data.status = ST_DONE;
                  out_data.slot   = cmd_ff.slot;
                  out_data.owner  = cslot_ok ? owner_ff[cidx] : 8'd0;
                  out_data.last   = 1'b1;
                  state_in        = S_IDLE;
               end
            end else if (!placed_ff && head.slot == cmd_ff.slot) begin
               popq      = 1'b1;
               len_in    = len_ff - LW'(1);
               placed_in = 1'b1;
               if ((cnt_ff + LW'(1)) < walk_ff) begin
                  hd_wr  = 1'b1;
                  hd_val = second.delta + head.delta;
               end
               cnt_in = cnt_ff + LW'(1);
            end else begin
               rot    = 1'b1;
               cnt_in = cnt_ff + LW'(1);
            end
         end
         S_TICK: begin
            if (len_ff != '0 && head.delta == 32'd0 && int'(n_ff) < MAX_BURST) begin
               if (!out_full) begin
                  out_push        = 1'b1;
                  out_data.status = ST_EXPIRED;
                  out_data.slot   = head.slot;
                  out_data.owner  = head.owner;
                  out_data.last   = (len_ff == LW'(1)) || (second.delta != 32'd0)
                                    || (int'(n_ff) == MAX_BURST - 1);
                  active_in[hidx] = 1'b0;
                  popq            = 1'b1;
                  len_in          = len_ff - LW'(1);
                  n_in            = n_ff + 5'd1;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      q_in = q_ff;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (rot) begin
            if (i + 1 < int'(len_ff)) begin
               q_in[i] = q_ff[(i + 1) % NUM_TIMERS];
            end else if (i + 1 == int'(len_ff)) begin
               q_in[i] = q_ff[0];
            end
         end
         if (popq && i < NUM_TIMERS - 1) begin
            q_in[i] = q_ff[(i + 1) % NUM_TIMERS];
         end
      end
      if (app) begin
         q_in[len_ff[IW-1:0]] = '{slot: cmd_ff.slot, owner: cmd_ff.owner, delta: rem_ff};
      end
      if (hd_wr) begin
         q_in[0].delta = hd_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         len_ff    <= '0;
         active_ff <= '0;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         active_ff <= active_in;
      end
      q_ff      <= q_in;
      owner_ff  <= owner_in;
      cnt_ff    <= cnt_in;
      walk_ff   <= walk_in;
      n_ff      <= n_in;
      rem_ff    <= rem_in;
      placed_ff <= placed_in;
      cmd_ff    <= cmd_in;
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      int'(len_ff) <= SLOTS)
      else $error("Timer list longer than the number of slots.");

   a_active_matches_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> $countones(active_ff) == int'(len_ff))
      else $error("Active slot count differs from list length.");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("Result written into a full result queue.");

   a_tick_burst: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TICK |-> int'(n_ff) <= MAX_BURST)
      else $error("Expiry burst exceeded its limit.");
endmodule

FILE: tb/tb.sv
// Testbench for the delta-list timer queue: adds, deletes and ticks against a
// local model of the ordered delta list, with random stalls on both sides.
// Depends on dltq_pkg and delta_list_timer_queue.
`timescale 1ns / 100ps

module tb
   import dltq_pkg::*;
();

   localparam int NT = 16;
   localparam logic [1:0] OP_TICK = 2'd2;
   localparam logic [1:0] OP_TICK_ALT = 2'd3;
   localparam int IDLE_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [1:0]  req_opcode = '0;
   logic [3:0]  req_timer_slot = '0;
   logic [7:0]  req_owner_id = '0;
   logic [31:0] req_delay_ticks = '0;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_slot_out;
   logic [7:0]  rsp_owner_out;
   logic        rsp_last;
   logic        empty;
   logic        pop = 1'b0;

   delta_list_timer_queue #(.NUM_TIMERS(NT)) u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Local copy of the timer list. An owner that was never stored is unknown.
   logic [3:0]  order_q [NT];
   logic [31:0] delta_q [NT];
   int          qlen;
   logic        armed [NT];
   logic [7:0]  owner_of [NT];

   rsp_type expected_rsps [$];
   int errors = 0;
   int n_requests = 0;
   int n_results = 0;
   int n_expired = 0;
   int idle_cycles = 0;
   bit hold_pop = 1'b0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
   endtask

   function automatic void drop_head_at(input int pos);
      for (int i = pos; i + 1 < qlen; i++) begin
         order_q[i] = order_q[i + 1];
         delta_q[i] = delta_q[i + 1];
      end
      qlen--;
   endfunction

   function automatic void timer_list_update(input logic [1:0] op, input logic [3:0] slot,
                                             input logic [7:0] own, input logic [31:0] dly);
      rsp_type r;
      logic [31:0] rem;
      int pos;
      int n;
      if (op == OP_ADD || op == OP_DEL) begin
         if (op == OP_ADD) begin
            if (dly == 0) r.status = ST_ZERO_DELAY;
            else if (armed[slot]) r.status = ST_ALREADY_ACTIVE;
            else begin
               rem = dly;
               pos = 0;
               while (pos < qlen) begin
                  if (rem < delta_q[pos]) begin
                     delta_q[pos] -= rem;
                     break;
                  end
                  rem -= delta_q[pos];
                  pos++;
               end
               for (int i = qlen; i > pos; i--) begin
                  order_q[i] = order_q[i - 1];
                  delta_q[i] = delta_q[i - 1];
               end
               order_q[pos] = slot;
               delta_q[pos] = rem;
               qlen++;
               armed[slot] = 1'b1;
               owner_of[slot] = own;
               r.status = ST_DONE;
            end
         end else begin
            if (!armed[slot]) r.status = ST_NOT_ACTIVE;
            else begin
               for (pos = 0; pos < qlen; pos++) if (order_q[pos] == slot) break;
               if (pos < qlen) begin
                  if (pos + 1 < qlen) delta_q[pos + 1] += delta_q[pos];
                  drop_head_at(pos);
               end
               armed[slot] = 1'b0;
               r.status = ST_DONE;
            end
         end
         r.slot = slot;
         r.owner = owner_of[slot];
         r.last = 1'b1;
         expected_rsps.push_back(r);
         return;
      end
      if (qlen == 0) return;
      if (delta_q[0] != 0) delta_q[0]--;
      n = 0;
      while (qlen > 0 && delta_q[0] == 0 && n < MAX_BURST) begin
         r.status = ST_EXPIRED;
         r.slot = order_q[0];
         r.owner = owner_of[order_q[0]];
         r.last = 1'b0;
         armed[order_q[0]] = 1'b0;
         drop_head_at(0);
         expected_rsps.push_back(r);
         n++;
      end
      if (n > 0) expected_rsps[$].last = 1'b1;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   bit quiet_sender = 1'b0;

   task automatic send_request(input logic [1:0] op, input logic [3:0] slot,
                               input logic [7:0] own, input logic [31:0] dly);
      int g;
      g = quiet_sender ? 0 : gap_len();
      if (g > 0) begin
         push <= 1'b0;
         repeat (g) @(posedge clock);
      end
      push <= 1'b1;
      req_opcode <= op;
      req_timer_slot <= slot;
      req_owner_id <= own;
      req_delay_ticks <= dly;
      do @(posedge clock); while (full);
      timer_list_update(op, slot, own, dly);
      n_requests++;
   endtask

   // Result side: random pop with a forced hold-off when asked.
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         n_results++;
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("MISMATCH unexpected result for slot %0d", rsp_slot_out);
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status) report("status", 32'(rsp_status), 32'(e.status));
            if (rsp_slot_out !== e.slot) report("slot", 32'(rsp_slot_out), 32'(e.slot));
            if (!$isunknown(e.owner) && rsp_owner_out !== e.owner)
               report("owner", 32'(rsp_owner_out), 32'(e.owner));
            if (rsp_last !== e.last) report("last", 32'(rsp_last), 32'(e.last));
            if (e.status == ST_EXPIRED) n_expired++;
         end
      end
      if (reset || hold_pop) pop <= 1'b0;
      else pop <= ($urandom_range(0, 9) < 7);
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress");
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic drain();
      push <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_delay();
      case ($urandom_range(0, 5))
         0: return 32'd1;
         1: return $urandom_range(1, 3);
         2: return $urandom();
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   task automatic test_directed();
      send_request(OP_ADD, 4'd0, 8'd0, 32'd0);
      send_request(OP_DEL, 4'd15, 8'd0, 32'd0);
      send_request(OP_TICK, 4'd0, 8'd0, 32'd0);
      send_request(OP_ADD, 4'd15, 8'hFF, 32'hFFFF_FFFF);
      send_request(OP_ADD, 4'd15, 8'h12, 32'd5);
      send_request(OP_ADD, 4'd0, 8'hA5, 32'd2);
      send_request(OP_ADD, 4'd1, 8'h5A, 32'd2);
      send_request(OP_ADD, 4'd2, 8'h33, 32'd1);
      send_request(OP_ADD, 4'd3, 8'h44, 32'd4);
      send_request(OP_DEL, 4'd3, 8'h00, 32'd0);
      send_request(OP_TICK_ALT, 4'd7, 8'hFF, 32'hFFFF_FFFF);
      send_request(OP_TICK, 4'd0, 8'd0, 32'd0);
      send_request(OP_TICK, 4'd0, 8'd0, 32'd0);
      send_request(OP_DEL, 4'd15, 8'd0, 32'd0);
      send_request(OP_DEL, 4'd15, 8'd0, 32'd0);
      send_request(OP_ADD, 4'd3, 8'd9, 32'h8000_0000);
      send_request(OP_DEL, 4'd3, 8'd0, 32'd0);
      drain();
   endtask

   task automatic test_full_burst();
      // All sixteen slots expire on one tick.
      for (int s = 0; s < NT; s++) send_request(OP_ADD, s[3:0], 8'($urandom()), 32'd3);
      repeat (3) send_request(OP_TICK, 4'd0, 8'd0, 32'd0);
      drain();
   endtask

   task automatic test_backpressure();
      hold_pop = 1'b1;
      quiet_sender = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_pop = 1'b0;
         end
         begin
            for (int i = 0; i < 24; i++)
               send_request(OP_ADD, 4'($urandom_range(0, 15)), 8'($urandom()), rand_delay());
            push <= 1'b0;
         end
      join
      quiet_sender = 1'b0;
      drain();
   endtask

   task automatic test_random();
      int k;
      for (int i = 0; i < 400; i++) begin
         k = $urandom_range(0, 99);
         if (k < 45)
            send_request(OP_ADD, 4'($urandom_range(0, 15)), 8'($urandom()),
                         ($urandom_range(0, 30) == 0) ? 32'd0 : rand_delay());
         else if (k < 60)
            send_request(OP_DEL, 4'($urandom_range(0, 15)), 8'($urandom()), $urandom());
         else
            send_request($urandom_range(0, 7) == 0 ? OP_TICK_ALT : OP_TICK,
                         4'($urandom()), 8'($urandom()), $urandom());
      end
      drain();
   endtask

   initial begin
      for (int s = 0; s < NT; s++) begin
         armed[s] = 1'b0;
         owner_of[s] = 'x;
      end
      qlen = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_burst();
      test_backpressure();
      test_random();
      $display("Sent %0d requests, checked %0d results, %0d of them expiries.",
               n_requests, n_results, n_expired);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
